/* design/sesw_pkg.sv */
// ----------------------------------------------------------------------------
// sesw_pkg: shared types and constants of the strided endian swapper
// Result record layout, register indexes, status codes and queue sizing.
// ----------------------------------------------------------------------------
package sesw_pkg;

  // Default width of the record position counter.
  localparam int SESW_POS_WIDTH = 16;

  // Result queue depth; one request may push up to MAX_RES results.
  // One entry above twice the burst keeps a full burst from stalling the
  // input while the previous result is still leaving.
  localparam int MAX_RES = 4;
  localparam int QDEPTH  = 9;
  localparam int CNT_W   = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_ELEM_SIZE     = 2'd0;
  localparam logic [1:0] REG_FIELD_OFFSET  = 2'd1;
  localparam logic [1:0] REG_ELEM_COUNT    = 2'd2;
  localparam logic [1:0] REG_RECORD_STRIDE = 2'd3;

  // Configuration reset values.
  localparam logic [2:0]  RST_ELEM_SIZE     = 3'd1;
  localparam logic [15:0] RST_FIELD_OFFSET  = 16'd0;
  localparam logic [15:0] RST_ELEM_COUNT    = 16'd1;
  localparam logic [15:0] RST_RECORD_STRIDE = 16'd1;

  // Status codes reported with the final byte of a buffer.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE   = 2'd1;
  localparam logic [1:0] ST_BAD_PARAM  = 2'd2;
  localparam logic [1:0] ST_MISALIGNED = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic       stream_end;
    logic       run_end;
    logic [7:0] data;
  } res_t;

  // Results produced by one request, in output order from index 0.
  typedef struct packed {
    logic [2:0]             n;
    res_t [MAX_RES-1:0]     r;
  } push_t;

endpackage

/* design/strided_endian_swap.sv */
// An accepted byte passes the input register, then the result queue, to out_.
// Throughput: one byte per cycle; a completed element leaves as a burst of up
// to four bytes from a nine-entry result queue, and in_tready drops only when
// the queue plus the byte in flight could not take another burst.
// Reset: synchronous on rst_n low; clears the queue, the held element and the
// record position, and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// strided_endian_swap: strided endian byte swapper
// Reverses the byte order of 2 or 4 byte elements inside fixed-stride records
// of a byte stream and reports a status with the final byte of each buffer.
// ----------------------------------------------------------------------------
module strided_endian_swap #(
  parameter int POS_WIDTH = sesw_pkg::SESW_POS_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_byte
  input  logic        in_tlast,   // in_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic        out_tlast,  // stream_end
  output logic [2:0]  out_tuser,  // [0] run_end, [2:1] status
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic [2:0]  elem_size_r;
  logic [15:0] field_offset_r, elem_count_r, record_stride_r;

  logic        iv_r;
  logic [7:0]  idata_r;
  logic        ilast_r;

  sesw_pkg::push_t                push;
  sesw_pkg::res_t                 head;
  logic                           head_valid;
  logic [sesw_pkg::CNT_W-1:0]     count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_size_r     <= sesw_pkg::RST_ELEM_SIZE;
      field_offset_r  <= sesw_pkg::RST_FIELD_OFFSET;
      elem_count_r    <= sesw_pkg::RST_ELEM_COUNT;
      record_stride_r <= sesw_pkg::RST_RECORD_STRIDE;
    end else if (cfg_we) begin
      case (cfg_addr)
        sesw_pkg::REG_ELEM_SIZE:     elem_size_r     <= cfg_wdata[2:0];
        sesw_pkg::REG_FIELD_OFFSET:  field_offset_r  <= cfg_wdata;
        sesw_pkg::REG_ELEM_COUNT:    elem_count_r    <= cfg_wdata;
        sesw_pkg::REG_RECORD_STRIDE: record_stride_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A request is taken only if the queue can still absorb a full burst from
  // it after the results of the request now in the input register.
  assign in_tready = ({1'b0, count} + (sesw_pkg::CNT_W+1)'(push.n)) <=
                     (sesw_pkg::CNT_W+1)'(sesw_pkg::QDEPTH - sesw_pkg::MAX_RES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else begin
      iv_r <= in_tvalid && in_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      idata_r <= in_tdata;
      ilast_r <= in_tlast;
    end
  end

  sesw_core #(
    .POS_WIDTH (POS_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (iv_r),
    .item_data     (idata_r),
    .item_last     (ilast_r),
    .elem_size     (elem_size_r),
    .field_offset  (field_offset_r),
    .elem_count    (elem_count_r),
    .record_stride (record_stride_r),
    .push          (push)
  );

  sesw_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_tvalid && out_tready),
    .head       (head),
    .head_valid (head_valid),
    .count      (count)
  );

  assign out_tvalid = head_valid;
  assign out_tdata  = head.data;
  assign out_tlast  = head.stream_end;
  assign out_tuser  = {head.status, head.run_end};

endmodule

/* design/sesw_core.sv */
// ----------------------------------------------------------------------------
// sesw_core: swap engine
// Tracks the record position and the partly received element, and works out
// the zero to four result bytes that each registered request produces.
// ----------------------------------------------------------------------------
module sesw_core #(
  parameter int POS_WIDTH = sesw_pkg::SESW_POS_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  logic [7:0]          item_data,
  input  logic                item_last,
  input  logic [2:0]          elem_size,
  input  logic [15:0]         field_offset,
  input  logic [15:0]         elem_count,
  input  logic [15:0]         record_stride,
  output sesw_pkg::push_t     push
);

  localparam int CW = (POS_WIDTH > 19) ? POS_WIDTH : 19;
  localparam int PW = (POS_WIDTH + 1 > 16) ? POS_WIDTH + 1 : 16;

  logic [7:0]           held_r [3];
  logic [1:0]           hcnt_r, hcnt_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt, pos_adv;

  logic        sized, sz4, params_ok, hit, flush_first, match, complete, hold;
  logic [17:0] span;
  logic [18:0] region_end;
  logic [1:0]  idx, last_idx, f1, k, hcnt_eff;
  logic [2:0]  n;
  logic        rev;
  logic [7:0]  rb [sesw_pkg::MAX_RES];
  logic [POS_WIDTH:0] p1;
  logic [1:0]  status;

  always_comb begin
    sized = (elem_size == 3'd2) || (elem_size == 3'd4);
    sz4   = (elem_size == 3'd4);
    span  = sz4 ? {elem_count, 2'b00} : {1'b0, elem_count, 1'b0};
    params_ok = (record_stride != 16'd0) && (field_offset <= record_stride) &&
                (18'(record_stride - field_offset) >= span);
    region_end = 19'(field_offset) + 19'(span);
    hit = sized && params_ok && (CW'(pos_r) >= CW'(field_offset)) &&
          (CW'(pos_r) < CW'(region_end));
    idx      = (pos_r[1:0] - field_offset[1:0]) & (sz4 ? 2'b11 : 2'b01);
    last_idx = sz4 ? 2'd3 : 2'd1;

    flush_first = !hit || (idx != hcnt_r);
    hcnt_eff    = flush_first ? 2'd0 : hcnt_r;
    match       = hit && (idx == hcnt_eff);
    complete    = match && (idx == last_idx);
    hold        = match && !complete;
    f1          = flush_first ? hcnt_r : 2'd0;

    rev = 1'b0;
    k   = f1;
    if (complete) begin
      rev = 1'b1;
      n   = 3'(idx) + 3'd1;
    end else if (hold && item_last) begin
      // The new byte closes the buffer: everything held goes out in order.
      k = hcnt_r;
      n = 3'(hcnt_r) + 3'd1;
    end else if (hold) begin
      n = 3'(f1);
    end else begin
      n = 3'(f1) + 3'd1;
    end

    if (rev) begin
      rb[0] = item_data;
      if (sz4) begin
        rb[1] = held_r[2];
        rb[2] = held_r[1];
        rb[3] = held_r[0];
      end else begin
        rb[1] = held_r[0];
        rb[2] = held_r[0];
        rb[3] = held_r[0];
      end
    end else begin
      rb[0] = (k > 2'd0) ? held_r[0] : item_data;
      rb[1] = (k > 2'd1) ? held_r[1] : item_data;
      rb[2] = (k > 2'd2) ? held_r[2] : item_data;
      rb[3] = item_data;
    end

    p1 = {1'b0, pos_r} + (POS_WIDTH+1)'(1);
    if ((record_stride == 16'd0) || (PW'(p1) >= PW'(record_stride))) begin
      pos_adv = '0;
    end else begin
      pos_adv = p1[POS_WIDTH-1:0];
    end

    if (elem_size == 3'd1) begin
      status = sesw_pkg::ST_OK;
    end else if (!sized) begin
      status = sesw_pkg::ST_BAD_SIZE;
    end else if (record_stride == 16'd0) begin
      status = sesw_pkg::ST_BAD_PARAM;
    end else if (pos_adv != '0) begin
      status = sesw_pkg::ST_MISALIGNED;
    end else if (!params_ok) begin
      status = sesw_pkg::ST_BAD_PARAM;
    end else begin
      status = sesw_pkg::ST_OK;
    end

    push.n = item_valid ? n : 3'd0;
    for (int j = 0; j < sesw_pkg::MAX_RES; j++) begin
      push.r[j].data       = rb[j];
      push.r[j].run_end    = (3'(j) == n - 3'd1);
      push.r[j].stream_end = item_last && (3'(j) == n - 3'd1);
      push.r[j].status     = (item_last && (3'(j) == n - 3'd1)) ? status
                                                                : sesw_pkg::ST_OK;
    end

    hcnt_nxt = (hold && !item_last) ? idx + 2'd1 : 2'd0;
    pos_nxt  = item_last ? '0 : pos_adv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r <= 2'd0;
      pos_r  <= '0;
    end else if (item_valid) begin
      hcnt_r <= hcnt_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && hold) begin
      held_r[idx] <= item_data;
    end
  end

endmodule

/* design/sesw_outq.sv */
// ----------------------------------------------------------------------------
// sesw_outq: result queue
// Shift queue that takes up to four results a cycle and hands out one a
// cycle, while pop is high, from its head register.
// ----------------------------------------------------------------------------
module sesw_outq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sesw_pkg::push_t             push,
  input  logic                        pop,
  output sesw_pkg::res_t              head,
  output logic                        head_valid,
  output logic [sesw_pkg::CNT_W-1:0]  count
);

  localparam int QD = sesw_pkg::QDEPTH;
  localparam int CW = sesw_pkg::CNT_W;

  sesw_pkg::res_t   q_r [QD];
  sesw_pkg::res_t   q_nxt [QD];
  logic [CW-1:0]    cnt_r, cnt_nxt, base;
  logic [CW:0]      slot;

  always_comb begin
    base = cnt_r - CW'(pop);
    for (int s = 0; s < QD; s++) begin
      if (pop && (s < QD - 1)) begin
        q_nxt[s] = q_r[(s + 1) % QD];
      end else begin
        q_nxt[s] = q_r[s];
      end
      for (int j = 0; j < sesw_pkg::MAX_RES; j++) begin
        slot = {1'b0, base} + (CW+1)'(j);
        if ((3'(j) < push.n) && (slot == (CW+1)'(s))) begin
          q_nxt[s] = push.r[j];
        end
      end
    end
    cnt_nxt = base + CW'(push.n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < QD; s++) begin
      q_r[s] <= q_nxt[s];
    end
  end

  assign head       = q_r[0];
  assign head_valid = (cnt_r != '0);
  assign count      = cnt_r;

endmodule

/* design/sesw_checker.sv */
// ----------------------------------------------------------------------------
// sesw_checker: port-level checks
// Watches the result channel of the swapper and is bound to its top level.
// ----------------------------------------------------------------------------
module sesw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [2:0] out_tuser
);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result request withdrawn while stalled");

  // A stalled result keeps its byte.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result byte changed while stalled");

  // The final byte of a buffer is always the last result of its request.
  a_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0])
    else $error("buffer end without run end");

  // Status is only carried on the final byte of a buffer.
  a_status_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser[2:1] == 2'd0)
    else $error("status set away from buffer end");

  // The queue comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

endmodule

bind strided_endian_swap sesw_checker u_sesw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

/* bench/tb_strided_endian_swap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_strided_endian_swap: self-checking bench for the strided endian swapper
// A short table of directed requests covers the status codes, broken elements
// and extreme register values. Random buffers under many register settings
// follow. Every output byte is checked against its plan row or a prediction.
// ----------------------------------------------------------------------------
module tb_strided_endian_swap;

  localparam int SETTLE       = 6;
  localparam int RANDOM_BYTES = 240;
  localparam int REPORT_LIMIT = 10;

  typedef enum logic [1:0] {ROW_SETUP, ROW_BYTE, ROW_TYPED} row_kind_t;

  // Setup rows use the register fields; byte rows use data and last, and
  // typed rows also give the status expected on a single pass-through byte.
  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  sz;
    logic [15:0] off;
    logic [15:0] cnt;
    logic [15:0] stride;
    logic [7:0]  data;
    logic        last;
    logic [1:0]  status;
  } row_t;

  localparam int PLAN_ROWS = 32;
  localparam row_t PLAN [PLAN_ROWS] = '{
    '{ROW_TYPED, 3'd0, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0, sesw_pkg::ST_OK},
    '{ROW_TYPED, 3'd0, 16'h0000, 16'h0000, 16'h0000, 8'hFF, 1'b1, sesw_pkg::ST_OK},
    '{ROW_SETUP, 3'd3, 16'h0000, 16'h0001, 16'h0001, 8'h00, 1'b0, sesw_pkg::ST_OK},
    '{ROW_TYPED, 3'd0, 16'h0000, 16'h0000, 16'h0000, 8'hA5, 1'b1, sesw_pkg::ST_BAD_SIZE},
    '{ROW_SETUP, 3'd2, 16'h0000, 16'h0001, 16'h0000, 8'h00, 1'b0, sesw_pkg::ST_OK},
    '{ROW_TYPED, 3'd0, 16'h0000, 16'h0000, 16'h0000, 8'h5A, 1'b1, sesw_pkg::ST_BAD_PARAM},
    '{ROW_SETUP, 3'd2, 16'h0000, 16'h0002, 16'h0004, 8'h00, 1'b0, sesw_pkg::ST_OK},
    '{ROW_BYTE,  3'd0, 16'h0000, 16'h0000, 16'h0000, 8'h11, 1'b0, sesw_pkg::ST_OK},
    '{ROW_BYTE,  3'd0, 16'h0000, 16'h0000, 16'h0000, 8'h22, 1'b0, sesw_pkg::ST_OK},
    '{ROW_BYTE,  3'd0, 16'h0000, 16'h0000, 16'h0000, 8'h33, 1'b0, sesw_pkg::ST_OK},
    '{ROW_BYTE,  3'd0, 16'h0000, 16'h0000, 16'h0000, 8'h44, 1'b1, sesw_pkg::ST_OK},
    '{ROW_TYPED, 3'd0, 16'h0000, 16'h0000, 16'h0000, 8'h01, 1'b1, sesw_pkg::ST_MISALIGNED},
    '{ROW_SETUP, 3'd4, 16'h0001, 16'h0001, 16'h0006, 8'h00, 1'b0, sesw_pkg::ST_OK},
    '{ROW_BYTE,  3'd0, 16'h0000, 16'h0000, 16'h0000, 8'h80, 1'b0, sesw_pkg::ST_OK},
    '{ROW_BYTE,  3'd0, 16'h0000, 16'h0000, 16'h0000, 8'h81, 1'b0, sesw_pkg::ST_OK},
    '{ROW_BYTE,  3'd0, 16'h0000, 16'h0000, 16'h0000, 8'h82, 1'b0, sesw_pkg::ST_OK},
    '{ROW_BYTE,  3'd0, 16'h0000, 16'h0000, 16'h0000, 8'h83, 1'b0, sesw_pkg::ST_OK},
    '{ROW_BYTE,  3'd0, 16'h0000, 16'h0000, 16'h0000, 8'h84, 1'b0, sesw_pkg::ST_OK},
    '{ROW_BYTE,  3'd0, 16'h0000, 16'h0000, 16'h0000, 8'h85, 1'b1, sesw_pkg::ST_OK},
    '{ROW_SETUP, 3'd2, 16'h0001, 16'h0001, 16'h0002, 8'h00, 1'b0, sesw_pkg::ST_OK},
    '{ROW_TYPED, 3'd0, 16'h0000, 16'h0000, 16'h0000, 8'h3C, 1'b0, sesw_pkg::ST_OK},
    '{ROW_TYPED, 3'd0, 16'h0000, 16'h0000, 16'h0000, 8'hC3, 1'b1, sesw_pkg::ST_BAD_PARAM},
    '{ROW_SETUP, 3'd4, 16'h0000, 16'h0001, 16'h0004, 8'h00, 1'b0, sesw_pkg::ST_OK},
    '{ROW_BYTE,  3'd0, 16'h0000, 16'h0000, 16'h0000, 8'h10, 1'b0, sesw_pkg::ST_OK},
    '{ROW_BYTE,  3'd0, 16'h0000, 16'h0000, 16'h0000, 8'h20, 1'b0, sesw_pkg::ST_OK},
    '{ROW_SETUP, 3'd2, 16'h0000, 16'h0001, 16'h0002, 8'h00, 1'b0, sesw_pkg::ST_OK},
    '{ROW_BYTE,  3'd0, 16'h0000, 16'h0000, 16'h0000, 8'h30, 1'b0, sesw_pkg::ST_OK},
    '{ROW_TYPED, 3'd0, 16'h0000, 16'h0000, 16'h0000, 8'h40, 1'b1, sesw_pkg::ST_MISALIGNED},
    '{ROW_SETUP, 3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 1'b0, sesw_pkg::ST_OK},
    '{ROW_TYPED, 3'd0, 16'h0000, 16'h0000, 16'h0000, 8'hE7, 1'b1, sesw_pkg::ST_BAD_SIZE},
    '{ROW_SETUP, 3'd4, 16'hFFFF, 16'h0000, 16'hFFFF, 8'h00, 1'b0, sesw_pkg::ST_OK},
    '{ROW_TYPED, 3'd0, 16'h0000, 16'h0000, 16'h0000, 8'h55, 1'b1, sesw_pkg::ST_MISALIGNED}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic [2:0]  out_tuser;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_addr   = sesw_pkg::REG_ELEM_SIZE;
  logic [15:0] cfg_wdata  = 16'h0000;

  // Register copies and swap state of the prediction.
  logic [2:0]  r_size   = sesw_pkg::RST_ELEM_SIZE;
  logic [15:0] r_offset = sesw_pkg::RST_FIELD_OFFSET;
  logic [15:0] r_count  = sesw_pkg::RST_ELEM_COUNT;
  logic [15:0] r_stride = sesw_pkg::RST_RECORD_STRIDE;
  logic [7:0]  exp_held [3];
  int unsigned exp_held_n = 0;
  logic [15:0] exp_pos    = '0;

  sesw_pkg::res_t item_res[$];
  sesw_pkg::res_t pending_bytes[$];

  bit no_gaps    = 1'b0;
  int stall_left = 0;
  int errors     = 0;
  int bytes_sent = 0;
  int buffers    = 0;
  int settings   = 0;
  int checked    = 0;

  strided_endian_swap u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_span();
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 25);
  endfunction

  function automatic int input_gap();
    if (no_gaps || $urandom_range(0, 99) < 60) begin
      return 0;
    end
    return idle_span();
  endfunction

  function automatic sesw_pkg::res_t plain_byte(input logic [7:0] b);
    sesw_pkg::res_t r;
    r      = '0;
    r.data = b;
    return r;
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < int'(exp_held_n); i++) begin
      item_res.push_back(plain_byte(exp_held[i]));
    end
    exp_held_n = 0;
  endfunction

  // Works out the output bytes caused by one input byte into item_res.
  function automatic void predict_swap(input logic [7:0] b, input logic last);
    int unsigned p, sz, off_u, cnt_u, stride_u, region_end, idx;
    bit          sized, fits;
    logic [1:0]  st;
    p          = exp_pos;
    sz         = r_size;
    off_u      = r_offset;
    cnt_u      = r_count;
    stride_u   = r_stride;
    sized      = (sz == 2 || sz == 4);
    fits       = stride_u != 0 && off_u <= stride_u && (stride_u - off_u) >= cnt_u * sz;
    region_end = off_u + cnt_u * sz;
    item_res.delete();

    if (sized && fits && p >= off_u && p < region_end) begin
      idx = (p - off_u) & (sz - 1);
      // A byte that does not continue the held element breaks it off.
      if (idx != exp_held_n) begin
        flush_held();
      end
      if (idx == exp_held_n) begin
        if (idx == sz - 1) begin
          item_res.push_back(plain_byte(b));
          for (int i = int'(exp_held_n); i > 0; i--) begin
            item_res.push_back(plain_byte(exp_held[i - 1]));
          end
          exp_held_n = 0;
        end else begin
          exp_held[idx] = b;
          exp_held_n    = idx + 1;
        end
      end else begin
        item_res.push_back(plain_byte(b));
      end
    end else begin
      flush_held();
      item_res.push_back(plain_byte(b));
    end

    if (last) begin
      flush_held();
    end
    if (stride_u == 0 || p + 1 >= stride_u) begin
      exp_pos = '0;
    end else begin
      exp_pos = 16'(p + 1);
    end

    if (last) begin
      if (sz == 1) begin
        st = sesw_pkg::ST_OK;
      end else if (!sized) begin
        st = sesw_pkg::ST_BAD_SIZE;
      end else if (stride_u == 0) begin
        st = sesw_pkg::ST_BAD_PARAM;
      end else if (exp_pos != '0) begin
        st = sesw_pkg::ST_MISALIGNED;
      end else if (!fits) begin
        st = sesw_pkg::ST_BAD_PARAM;
      end else begin
        st = sesw_pkg::ST_OK;
      end
      item_res[item_res.size() - 1].stream_end = 1'b1;
      item_res[item_res.size() - 1].status     = st;
      exp_pos    = '0;
      exp_held_n = 0;
    end
    if (item_res.size() != 0) begin
      item_res[item_res.size() - 1].run_end = 1'b1;
    end
  endfunction

  function automatic void flag_error(input sesw_pkg::res_t want, input sesw_pkg::res_t got,
                                     input bit stray);
    errors++;
    if (errors <= REPORT_LIMIT) begin
      if (stray) begin
        $display("%0t: unexpected output byte %h run_end %b stream_end %b status %0d",
                 $time, got.data, got.run_end, got.stream_end, got.status);
      end else begin
        $display("%0t: mismatch, expected byte %h run_end %b stream_end %b status %0d",
                 $time, want.data, want.run_end, want.stream_end, want.status);
        $display("%0t:           actual   byte %h run_end %b stream_end %b status %0d",
                 $time, got.data, got.run_end, got.stream_end, got.status);
      end
    end
  endfunction

  // Waits for the block to drain, then writes all four registers.
  task automatic program_regs(input logic [2:0] sz, input logic [15:0] off,
                              input logic [15:0] cnt, input logic [15:0] stride);
    in_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= sesw_pkg::REG_ELEM_SIZE;
    cfg_wdata <= {13'd0, sz};
    @(posedge clk);
    cfg_addr  <= sesw_pkg::REG_FIELD_OFFSET;
    cfg_wdata <= off;
    @(posedge clk);
    cfg_addr  <= sesw_pkg::REG_ELEM_COUNT;
    cfg_wdata <= cnt;
    @(posedge clk);
    cfg_addr  <= sesw_pkg::REG_RECORD_STRIDE;
    cfg_wdata <= stride;
    @(posedge clk);
    cfg_we   <= 1'b0;
    r_size   = sz;
    r_offset = off;
    r_count  = cnt;
    r_stride = stride;
    settings++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input sesw_pkg::res_t want);
    int gap;
    gap = input_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    predict_swap(b, last);
    if (typed) begin
      pending_bytes.push_back(want);
    end else begin
      foreach (item_res[i]) pending_bytes.push_back(item_res[i]);
    end
    bytes_sent++;
    if (last) begin
      buffers++;
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (!no_gaps && $urandom_range(0, 9) < 2) begin
        stall_left <= idle_span();
      end
    end
  end

  always @(posedge clk) begin
    sesw_pkg::res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.data       = out_tdata;
      got.run_end    = out_tuser[0];
      got.status     = out_tuser[2:1];
      got.stream_end = out_tlast;
      checked++;
      if (pending_bytes.size() == 0) begin
        flag_error(got, got, 1'b1);
      end else begin
        want = pending_bytes.pop_front();
        if (got.data !== want.data || got.run_end !== want.run_end ||
            got.stream_end !== want.stream_end || got.status !== want.status) begin
          flag_error(want, got, 1'b0);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    sesw_pkg::res_t want;
    int             r, nbuf, span, len, rand_bytes;
    int unsigned    room;
    logic [2:0]     sz;
    logic [15:0]    off, cnt, stride;
    bit             leave_open;
    rand_bytes = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      want = '{status: PLAN[i].status, stream_end: PLAN[i].last, run_end: 1'b1,
               data: PLAN[i].data};
      case (PLAN[i].kind)
        ROW_SETUP: begin
          program_regs(PLAN[i].sz, PLAN[i].off, PLAN[i].cnt, PLAN[i].stride);
        end
        ROW_BYTE: begin
          send_byte(PLAN[i].data, PLAN[i].last, 1'b0, want);
        end
        default: begin
          send_byte(PLAN[i].data, PLAN[i].last, 1'b1, want);
        end
      endcase
    end

    while (rand_bytes < RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        sz     = 3'($urandom_range(0, 7));
        off    = 16'($urandom);
        cnt    = 16'($urandom);
        stride = 16'($urandom);
      end else begin
        stride = 16'($urandom_range(1, 12));
        if (r < 16) begin
          sz = 3'd1;
        end else if (r < 22) begin
          do sz = 3'($urandom_range(0, 7)); while (sz == 1 || sz == 2 || sz == 4);
        end else begin
          sz = ($urandom_range(0, 1) != 0) ? 3'd4 : 3'd2;
        end
        off  = 16'($urandom_range(0, stride));
        room = (sz == 0) ? 0 : (stride - off) / sz;
        cnt  = (room == 0) ? 16'd0 : 16'($urandom_range(1, room));
        // Now and then one element too many, or no stride at all.
        if ($urandom_range(0, 7) == 0) begin
          cnt = cnt + 16'd1;
        end
        if ($urandom_range(0, 19) == 0) begin
          stride = 16'd0;
        end
      end
      program_regs(sz, off, cnt, stride);
      no_gaps = ($urandom_range(0, 3) == 0);

      nbuf = $urandom_range(1, 3);
      for (int k = 0; k < nbuf; k++) begin
        span = (stride == 0 || stride > 16) ? $urandom_range(1, 10) : int'(stride);
        len  = span * $urandom_range(1, 3);
        if ($urandom_range(0, 4) == 0) begin
          len = $urandom_range(1, len + 3);
        end
        // An unfinished last buffer lets the next setting land mid-record.
        leave_open = (k == nbuf - 1) && ($urandom_range(0, 4) == 0);
        for (int j = 0; j < len; j++) begin
          send_byte(8'($urandom_range(0, 255)), (j == len - 1) && !leave_open, 1'b0, want);
        end
        rand_bytes += len;
      end
    end

    in_tvalid <= 1'b0;
    no_gaps = 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE * 2) @(posedge clk);

    $display("Sent %0d bytes in %0d closed buffers under %0d register settings.",
             bytes_sent, buffers, settings);
    $display("Checked %0d output bytes; %0d mismatches.", checked, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
